// ----- sv/segi_pkg.sv -----
`timescale 1ns / 1ps
package segi_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Per-word control that travels down the pipe with the data.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } segi_ctl_t;

endpackage

// ----- sv/segi_ifs.sv -----
`timescale 1ns / 1ps
interface segi_in_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segi_out_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;

  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

// ----- sv/segi_front.sv -----
`timescale 1ns / 1ps
module segi_front import segi_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [W-1:0]       asx,
  input  logic signed [W-1:0]       asy,
  input  logic signed [W-1:0]       aex,
  input  logic signed [W-1:0]       aey,
  input  logic signed [W-1:0]       bsx,
  input  logic signed [W-1:0]       bsy,
  input  logic signed [W-1:0]       bex,
  input  logic signed [W-1:0]       bey,
  output segi_ctl_t                 ctl_o,
  output logic [2*(W+1):0]          num_o,
  output logic [2*(W+1):0]          den_o,
  output logic [W-1:0]              mx_o,
  output logic [W-1:0]              my_o,
  output logic signed [W-1:0]       asx_o,
  output logic signed [W-1:0]       asy_o
);
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  // stage 1: edge vectors
  logic                 v1_r;
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [W-1:0]  asx1_r, asy1_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] p_ab_r, p_ba_r, p_ac_r, p_ca_r, p_bc_r, p_cb_r;
  logic [W-1:0]         mx2_r, my2_r;
  logic                 nx2_r, ny2_r;
  logic signed [W-1:0]  asx2_r, asy2_r;
  // stage 3: cross products
  logic                 v3_r;
  logic signed [XW-1:0] d3_r, s3_r, t3_r;
  logic [W-1:0]         mx3_r, my3_r;
  logic                 nx3_r, ny3_r;
  logic signed [W-1:0]  asx3_r, asy3_r;
  // stage 4
  segi_ctl_t            ctl4_r;
  logic [XW-1:0]        num4_r, den4_r;
  logic [W-1:0]         mx4_r, my4_r;
  logic signed [W-1:0]  asx4_r, asy4_r;

  logic signed [DW-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt, cx_nxt, cy_nxt;
  logic signed [XW-1:0] n3;
  logic                 hit_nxt;

  function automatic logic signed [DW-1:0] sx1(input logic signed [W-1:0] v);
    return $signed({v[W-1], v});
  endfunction

  function automatic logic signed [XW-1:0] sxp(input logic signed [PW-1:0] v);
    return $signed({v[PW-1], v});
  endfunction

  function automatic logic [W-1:0] magd(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] m;
    m = v[DW-1] ? -v : v;
    return m[W-1:0];
  endfunction

  function automatic logic [XW-1:0] magx(input logic signed [XW-1:0] v);
    return v[XW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  always_comb begin
    ax_nxt = sx1(aex) - sx1(asx);
    ay_nxt = sx1(aey) - sx1(asy);
    bx_nxt = sx1(bex) - sx1(bsx);
    by_nxt = sx1(bey) - sx1(bsy);
    cx_nxt = sx1(bex) - sx1(aex);
    cy_nxt = sx1(bey) - sx1(aey);
  end

  always_comb begin
    n3 = d3_r - t3_r;
    if (d3_r == '0) begin
      hit_nxt = 1'b0;
    end else if (!d3_r[XW-1]) begin
      hit_nxt = !s3_r[XW-1] && !t3_r[XW-1] && (s3_r <= d3_r) && (t3_r <= d3_r);
    end else begin
      hit_nxt = (s3_r <= 0) && (t3_r <= 0) && (s3_r >= d3_r) && (t3_r >= d3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ctl4_r <= '0;
    end else if (en) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      ctl4_r.valid <= v3_r;
      ctl4_r.hit   <= hit_nxt;
      ctl4_r.neg_x <= nx3_r;
      ctl4_r.neg_y <= ny3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      asx1_r <= asx;
      asy1_r <= asy;

      p_ab_r <= ax_r * by_r;
      p_ba_r <= ay_r * bx_r;
      p_ac_r <= ax_r * cy_r;
      p_ca_r <= ay_r * cx_r;
      p_bc_r <= bx_r * cy_r;
      p_cb_r <= by_r * cx_r;
      mx2_r  <= magd(ax_r);
      my2_r  <= magd(ay_r);
      nx2_r  <= ax_r[DW-1];
      ny2_r  <= ay_r[DW-1];
      asx2_r <= asx1_r;
      asy2_r <= asy1_r;

      d3_r   <= sxp(p_ab_r) - sxp(p_ba_r);
      s3_r   <= sxp(p_ac_r) - sxp(p_ca_r);
      t3_r   <= sxp(p_bc_r) - sxp(p_cb_r);
      mx3_r  <= mx2_r;
      my3_r  <= my2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      asx3_r <= asx2_r;
      asy3_r <= asy2_r;

      num4_r <= magx(n3);
      den4_r <= magx(d3_r);
      mx4_r  <= mx3_r;
      my4_r  <= my3_r;
      asx4_r <= asx3_r;
      asy4_r <= asy3_r;
    end
  end

  assign ctl_o = ctl4_r;
  assign num_o = num4_r;
  assign den_o = den4_r;
  assign mx_o  = mx4_r;
  assign my_o  = my4_r;
  assign asx_o = asx4_r;
  assign asy_o = asy4_r;
endmodule

// ----- sv/segi_div_stage.sv -----
`timescale 1ns / 1ps
module segi_div_stage import segi_pkg::*; #(
  parameter int W   = COORD_BITS_DEF,
  parameter int XW  = 2 * (W + 1) + 1,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  segi_ctl_t           ctl_i,
  input  logic [XW-1:0]       num_i,
  input  logic [XW-1:0]       den_i,
  input  logic [W-1:0]        mx_i,
  input  logic [W-1:0]        my_i,
  input  logic [XW-1:0]       rx_i,
  input  logic [XW-1:0]       ry_i,
  input  logic [W-1:0]        qx_i,
  input  logic [W-1:0]        qy_i,
  input  logic signed [W-1:0] asx_i,
  input  logic signed [W-1:0] asy_i,
  output segi_ctl_t           ctl_o,
  output logic [XW-1:0]       num_o,
  output logic [XW-1:0]       den_o,
  output logic [W-1:0]        mx_o,
  output logic [W-1:0]        my_o,
  output logic [XW-1:0]       rx_o,
  output logic [XW-1:0]       ry_o,
  output logic [W-1:0]        qx_o,
  output logic [W-1:0]        qy_o,
  output logic signed [W-1:0] asx_o,
  output logic signed [W-1:0] asy_o
);
  segi_ctl_t           ctl_r;
  logic [XW-1:0]       num_r, den_r, rx_r, ry_r;
  logic [W-1:0]        mx_r, my_r, qx_r, qy_r;
  logic signed [W-1:0] asx_r, asy_r;
  logic [XW+W-1:0]     lx_nxt, ly_nxt;

  // One bit of floor(n*m/d): r stays below d, q counts whole multiples.
  function automatic logic [XW+W-1:0] step(input logic [XW-1:0] r, input logic [W-1:0] q,
                                           input logic b, input logic [XW-1:0] d,
                                           input logic [XW-1:0] n);
    logic [XW:0]   r2, r1, r3, dd;
    logic          c1, c2;
    logic [W-1:0]  qn;
    dd = {1'b0, d};
    r2 = {r, 1'b0};
    c1 = r2 >= dd;
    r1 = c1 ? r2 - dd : r2;
    r3 = r1 + (b ? {1'b0, n} : '0);
    c2 = r3 >= dd;
    r3 = c2 ? r3 - dd : r3;
    qn = {q[W-2:0], 1'b0} + W'(c1) + W'(c2);
    return {r3[XW-1:0], qn};
  endfunction

  assign lx_nxt = step(rx_i, qx_i, mx_i[BIT], den_i, num_i);
  assign ly_nxt = step(ry_i, qy_i, my_i[BIT], den_i, num_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_i;
      den_r <= den_i;
      mx_r  <= mx_i;
      my_r  <= my_i;
      rx_r  <= lx_nxt[XW+W-1:W];
      qx_r  <= lx_nxt[W-1:0];
      ry_r  <= ly_nxt[XW+W-1:W];
      qy_r  <= ly_nxt[W-1:0];
      asx_r <= asx_i;
      asy_r <= asy_i;
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign mx_o  = mx_r;
  assign my_o  = my_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;
  assign asx_o = asx_r;
  assign asy_o = asy_r;
endmodule

// ----- sv/segment_intersection_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; four front stages,
//   one divider stage per bit of the edge length, one rounding/output register.
// The whole pipe advances together whenever the output register is empty or taken.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module segment_intersection_unit import segi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  segi_in_if.sink    in_seg,
  segi_out_if.source out_seg
);
  localparam int W  = COORD_BITS;
  localparam int XW = 2 * (W + 1) + 1;
  localparam int NS = W;  // divider stages, one per magnitude bit

  logic en;

  // Stage arrays: index 0 is the front output, index NS the last divider stage.
  segi_ctl_t           ctl_s [NS+1];
  logic [XW-1:0]       num_s [NS+1];
  logic [XW-1:0]       den_s [NS+1];
  logic [W-1:0]        mx_s  [NS+1];
  logic [W-1:0]        my_s  [NS+1];
  logic [XW-1:0]       rx_s  [NS+1];
  logic [XW-1:0]       ry_s  [NS+1];
  logic [W-1:0]        qx_s  [NS+1];
  logic [W-1:0]        qy_s  [NS+1];
  logic signed [W-1:0] asx_s [NS+1];
  logic signed [W-1:0] asy_s [NS+1];

  logic                out_valid_r;
  logic                hit_r;
  logic signed [W-1:0] px_r, py_r;
  logic signed [W-1:0] px_nxt, py_nxt;

  // Stall: everything moves when the output slot is free.
  assign en           = !out_valid_r || out_seg.ready;
  assign in_seg.ready = en;

  segi_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_seg.valid),
    .asx      (in_seg.a_start_x),
    .asy      (in_seg.a_start_y),
    .aex      (in_seg.a_end_x),
    .aey      (in_seg.a_end_y),
    .bsx      (in_seg.b_start_x),
    .bsy      (in_seg.b_start_y),
    .bex      (in_seg.b_end_x),
    .bey      (in_seg.b_end_y),
    .ctl_o    (ctl_s[0]),
    .num_o    (num_s[0]),
    .den_o    (den_s[0]),
    .mx_o     (mx_s[0]),
    .my_o     (my_s[0]),
    .asx_o    (asx_s[0]),
    .asy_o    (asy_s[0])
  );

  // Remainder and quotient start at zero.
  assign rx_s[0] = '0;
  assign ry_s[0] = '0;
  assign qx_s[0] = '0;
  assign qy_s[0] = '0;

  // Restoring scaled divide, MSB of the edge magnitude first.
  for (genvar k = 0; k < NS; k++) begin : g_div
    segi_div_stage #(.W(W), .XW(XW), .BIT(NS - 1 - k)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_s[k]),
      .num_i (num_s[k]),
      .den_i (den_s[k]),
      .mx_i  (mx_s[k]),
      .my_i  (my_s[k]),
      .rx_i  (rx_s[k]),
      .ry_i  (ry_s[k]),
      .qx_i  (qx_s[k]),
      .qy_i  (qy_s[k]),
      .asx_i (asx_s[k]),
      .asy_i (asy_s[k]),
      .ctl_o (ctl_s[k+1]),
      .num_o (num_s[k+1]),
      .den_o (den_s[k+1]),
      .mx_o  (mx_s[k+1]),
      .my_o  (my_s[k+1]),
      .rx_o  (rx_s[k+1]),
      .ry_o  (ry_s[k+1]),
      .qx_o  (qx_s[k+1]),
      .qy_o  (qy_s[k+1]),
      .asx_o (asx_s[k+1]),
      .asy_o (asy_s[k+1])
    );
  end

  // Round half to even, apply edge sign, add the start point.
  function automatic logic signed [W-1:0] finish(input logic [XW-1:0] r,
                                                 input logic [W-1:0] q,
                                                 input logic [XW-1:0] d,
                                                 input logic neg,
                                                 input logic signed [W-1:0] st);
    logic [XW:0] r2, dd;
    logic        up;
    logic [W:0]  qr, off, sum;
    r2  = {r, 1'b0};
    dd  = {1'b0, d};
    up  = (r2 > dd) || ((r2 == dd) && q[0]);
    qr  = {1'b0, q} + (W+1)'(up);
    off = neg ? (~qr + 1'b1) : qr;
    sum = {st[W-1], st} + off;
    return $signed(sum[W-1:0]);
  endfunction

  assign px_nxt = finish(rx_s[NS], qx_s[NS], den_s[NS], ctl_s[NS].neg_x, asx_s[NS]);
  assign py_nxt = finish(ry_s[NS], qy_s[NS], den_s[NS], ctl_s[NS].neg_y, asy_s[NS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[NS].valid;
    end
  end

  // Miss words report the origin.
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= ctl_s[NS].hit;
      px_r  <= ctl_s[NS].hit ? px_nxt : '0;
      py_r  <= ctl_s[NS].hit ? py_nxt : '0;
    end
  end

  assign out_seg.valid   = out_valid_r;
  assign out_seg.hit     = hit_r;
  assign out_seg.point_x = px_r;
  assign out_seg.point_y = py_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> px_r == '0 && py_r == '0)
    else $error("miss word carries a nonzero point");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_seg.ready |=> out_valid_r && $stable(hit_r) && $stable(px_r)
                                      && $stable(py_r))
    else $error("stalled output word changed");

  a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_s[0]))
    else $error("front moved during a stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_seg.ready)
    else $error("input stalled with empty output");
endmodule

// ----- tb/segment_intersection_unit_tb.sv -----
`timescale 1ns / 1ps
module segment_intersection_unit_tb;
  import segi_pkg::*;

  localparam int W = COORD_BITS_DEF;
  localparam int LAT = W + 4;          // front stages plus divider stages, used as a drain margin
  localparam int N_RANDOM = 1930;

  typedef logic signed [W-1:0] coord_t;

  // one segment pair as sent on the input channel
  typedef struct {
    coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
    bit     drain;                     // hold this word until the pipe has emptied
  } seg_pair_t;

  // one result word
  typedef struct {
    logic   hit;
    coord_t px, py;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  segi_in_if  #(.W(W)) in_seg ();
  segi_out_if #(.W(W)) out_seg ();

  segment_intersection_unit #(.COORD_BITS(W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg),
    .out_seg(out_seg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seg_pair_t pairs_q[$];       // words still to be sent
  crossing_t crossings_q[$];   // results owed by the block, oldest first
  int        n_fail = 0;
  bit        quiet_in = 1'b0;  // stretches with no gaps on either side
  bit        quiet_out = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor: exact integer cross products, rational point rounded half-even.
  // --------------------------------------------------------------------------
  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // round(|num| * |comp| / |den|) with ties to even, sign taken from comp
  function automatic longint axis_shift(longint num, longint den, longint comp);
    longint p, q, r, d;
    d = abs64(den);
    p = abs64(num) * abs64(comp);   // < 2^53, no overflow
    q = p / d;
    r = p % d;
    if (2 * r > d || (2 * r == d && q[0]))
      q++;
    return (comp < 0) ? -q : q;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t sp);
    crossing_t res;
    longint ax, ay, bx, by, cx, cy, dd, ss, tt, px, py;
    bit hit;
    ax = longint'(sp.aex) - longint'(sp.asx);
    ay = longint'(sp.aey) - longint'(sp.asy);
    bx = longint'(sp.bex) - longint'(sp.bsx);
    by = longint'(sp.bey) - longint'(sp.bsy);
    cx = longint'(sp.bex) - longint'(sp.aex);
    cy = longint'(sp.bey) - longint'(sp.aey);
    dd = ax * by - ay * bx;
    ss = ax * cy - ay * cx;
    tt = bx * cy - by * cx;
    if (dd == 0)
      hit = 1'b0;                      // parallel or degenerate
    else if (dd > 0)
      hit = ss >= 0 && tt >= 0 && ss <= dd && tt <= dd;
    else
      hit = ss <= 0 && tt <= 0 && ss >= dd && tt >= dd;
    res.hit = hit;
    res.px = '0;
    res.py = '0;
    if (hit) begin
      px = longint'(sp.asx) + axis_shift(dd - tt, dd, ax);
      py = longint'(sp.asy) + axis_shift(dd - tt, dd, ay);
      res.px = px[W-1:0];
      res.py = py[W-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic seg_pair_t mk_pair(int asx, int asy, int aex, int aey,
                                        int bsx, int bsy, int bex, int bey);
    seg_pair_t sp;
    sp.asx = asx[W-1:0]; sp.asy = asy[W-1:0];
    sp.aex = aex[W-1:0]; sp.aey = aey[W-1:0];
    sp.bsx = bsx[W-1:0]; sp.bsy = bsy[W-1:0];
    sp.bex = bex[W-1:0]; sp.bey = bey[W-1:0];
    sp.drain = 1'b0;
    return sp;
  endfunction

  function automatic int rnd_in(int lim);
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // segment B is aimed through a point on segment A, so most of these hit
  function automatic seg_pair_t crossing_pair(int lim);
    int asx, asy, aex, aey, px, py, vx, vy, k;
    asx = rnd_in(lim); asy = rnd_in(lim);
    aex = rnd_in(lim); aey = rnd_in(lim);
    k = $urandom_range(0, 16);
    px = asx + ((aex - asx) * k) / 16;
    py = asy + ((aey - asy) * k) / 16;
    vx = rnd_in(lim / 4 + 1);
    vy = rnd_in(lim / 4 + 1);
    k = $urandom_range(0, 3);
    return mk_pair(asx, asy, aex, aey, px + vx, py + vy, px - k * vx, py - k * vy);
  endfunction

  function automatic seg_pair_t noise_pair();
    seg_pair_t sp;
    sp.asx = W'($urandom); sp.asy = W'($urandom);
    sp.aex = W'($urandom); sp.aey = W'($urandom);
    sp.bsx = W'($urandom); sp.bsy = W'($urandom);
    sp.bex = W'($urandom); sp.bey = W'($urandom);
    sp.drain = 1'b0;
    return sp;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one word at a time from pairs_q, random gaps between words.
  // --------------------------------------------------------------------------
  int in_gap = 0;

  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_seg.valid <= 1'b0;
      in_gap = 0;
    end else begin
      nv = in_seg.valid;
      if (in_seg.valid && in_seg.ready) begin
        crossings_q.push_back(predict_crossing(pairs_q[0]));
        void'(pairs_q.pop_front());
        nv = 1'b0;
        in_gap = pick_gap(quiet_in);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pairs_q.size() > 0 &&
                     !(pairs_q[0].drain && crossings_q.size() > 0)) begin
          in_seg.a_start_x <= pairs_q[0].asx;
          in_seg.a_start_y <= pairs_q[0].asy;
          in_seg.a_end_x   <= pairs_q[0].aex;
          in_seg.a_end_y   <= pairs_q[0].aey;
          in_seg.b_start_x <= pairs_q[0].bsx;
          in_seg.b_start_y <= pairs_q[0].bsy;
          in_seg.b_end_x   <= pairs_q[0].bex;
          in_seg.b_end_y   <= pairs_q[0].bey;
          nv = 1'b1;
        end
      end
      in_seg.valid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result word, then stalls the sink at random.
  // --------------------------------------------------------------------------
  int out_gap = 0;

  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      out_seg.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_seg.valid && out_seg.ready) begin
        if (crossings_q.size() == 0) begin
          $error("result word with nothing expected: hit=%0b x=%0d y=%0d",
                 out_seg.hit, out_seg.point_x, out_seg.point_y);
          n_fail++;
        end else begin
          want = crossings_q.pop_front();
          if (out_seg.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, out_seg.hit);
            n_fail++;
          end
          if (out_seg.point_x !== want.px) begin
            $error("point_x: expected %0d, got %0d", want.px, out_seg.point_x);
            n_fail++;
          end
          if (out_seg.point_y !== want.py) begin
            $error("point_y: expected %0d, got %0d", want.py, out_seg.point_y);
            n_fail++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_seg.ready <= 1'b0;
      end else begin
        out_gap = pick_gap(quiet_out);
        out_seg.ready <= (out_gap == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed corners, then random words, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    seg_pair_t sp;
    int kind;
    in_seg.valid = 1'b0;
    in_seg.a_start_x = '0; in_seg.a_start_y = '0;
    in_seg.a_end_x = '0;   in_seg.a_end_y = '0;
    in_seg.b_start_x = '0; in_seg.b_start_y = '0;
    in_seg.b_end_x = '0;   in_seg.b_end_y = '0;
    out_seg.ready = 1'b0;

    // plain X crossing
    pairs_q.push_back(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));
    // ties: 1.5 -> 2, 2.5 -> 2, -1.5 -> -2
    pairs_q.push_back(mk_pair(0, 0, 3, 0, 1, -1, 2, 1));
    pairs_q.push_back(mk_pair(0, 0, 5, 0, 2, -1, 3, 1));
    pairs_q.push_back(mk_pair(0, 0, -3, 0, -1, -1, -2, 1));
    // parallel, collinear overlap, degenerate (zero-length segments)
    pairs_q.push_back(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));
    pairs_q.push_back(mk_pair(0, 0, 10, 0, 5, 0, 20, 0));
    pairs_q.push_back(mk_pair(3, 3, 3, 3, 3, 3, 3, 3));
    pairs_q.push_back(mk_pair(3, 3, 3, 3, 0, 0, 9, 9));
    // touching at endpoints, and a near miss
    pairs_q.push_back(mk_pair(0, 0, 10, 0, 10, 0, 10, 10));
    pairs_q.push_back(mk_pair(0, 0, 10, 0, 0, 0, 0, -10));
    pairs_q.push_back(mk_pair(0, 0, 10, 0, 11, -5, 11, 5));
    // positive D orientation; the plain X crossing has negative D
    pairs_q.push_back(mk_pair(0, 10, 10, 0, 0, 0, 10, 10));
    // extremes of the coordinate range
    pairs_q.push_back(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pairs_q.push_back(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    pairs_q.push_back(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    pairs_q.push_back(mk_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 0));
    pairs_q.push_back(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pairs_q.push_back(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                              -32768));
    pairs_q.push_back(mk_pair(-32768, -32767, 32767, 32766, -32767, 32767, 32766, -32768));
    pairs_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45)
        sp = crossing_pair(7000);
      else if (kind < 65)
        sp = crossing_pair(20);
      else if (kind < 85)
        sp = noise_pair();
      else
        sp = mk_pair(rnd_in(8), rnd_in(8), rnd_in(8), rnd_in(8),
                     rnd_in(8), rnd_in(8), rnd_in(8), rnd_in(8));
      sp.drain = (i == N_RANDOM / 2);   // one full pipe drain mid-run
      pairs_q.push_back(sp);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // alternate gappy and gap-free stretches until everything is sent
    while (pairs_q.size() > 0 || in_seg.valid) begin
      repeat (150) @(posedge clk);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
    end
    wait (crossings_q.size() == 0);
    repeat (LAT + 20) @(posedge clk);

    if (n_fail == 0)
      $display("[segment_intersection_unit] OK");
    else
      $display("[segment_intersection_unit] ERROR");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[segment_intersection_unit] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/segi_pkg.sv
sv/segi_ifs.sv
sv/segi_front.sv
sv/segi_div_stage.sv
sv/segment_intersection_unit.sv
tb/segment_intersection_unit_tb.sv
